@@ sv/keyword_prefix_matcher_assert.svh @@
// ----------------------------------------------------------------------------
// Keyword prefix matcher assertion macros
// Clocked property wrappers used by the RTL file that asserts.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_PREFIX_MATCHER_ASSERT_SVH
`define KEYWORD_PREFIX_MATCHER_ASSERT_SVH

// checked only out of reset
`define KPM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define KPM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/kpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyword prefix matcher package
// Field widths, command codes and the evaluation status type.
// ----------------------------------------------------------------------------
package kpm_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned KwIdxW    = 4;
  localparam int unsigned CharIdxW  = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned KwLenW    = 6;
  localparam int unsigned KwCountW  = 5;
  localparam int unsigned MatchLenW = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_KW_BYTE = 2'd0,
    CMD_KW_LEN  = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic                 act;
    logic                 emit;
    logic [MatchLenW-1:0] match_length;
  } eval_t;

endpackage

@@ sv/kpm_kw_bank.sv @@
// ----------------------------------------------------------------------------
// Keyword byte bank
// One keyword's bytes: single write port, single registered read port.
// ----------------------------------------------------------------------------
module kpm_kw_bank import kpm_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    wa_i,
  input  logic [ByteW-1:0] wd_i,
  input  logic             re_i,
  input  logic [AW-1:0]    ra_i,
  output logic [ByteW-1:0] rd_o
);

  logic [ByteW-1:0] mem [DEPTH];
  logic [ByteW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

@@ sv/kpm_eval.sv @@
// ----------------------------------------------------------------------------
// Keyword prefix matcher evaluation
// Compares one text byte against every alive keyword and decides the result.
// ----------------------------------------------------------------------------
module kpm_eval import kpm_pkg::*; #(
  parameter int unsigned NK = 16,
  parameter int unsigned KL = 32,
  localparam int unsigned LW = $clog2(KL + 1)
) (
  input  logic                start_i,
  input  logic                last_i,
  input  logic                decided_i,
  input  logic [NK-1:0]       alive_i,
  input  logic [LW-1:0]       pos_i,
  input  logic [ByteW-1:0]    byte_i,
  input  logic [ByteW-1:0]    kw_byte_i [NK],
  input  logic [LW-1:0]       len_i [NK],
  input  logic [KwCountW-1:0] count_i,
  output logic [NK-1:0]       alive_o,
  output eval_t               status_o
);

  logic [NK-1:0] base;
  logic [NK-1:0] alive0;
  logic [NK-1:0] alive1;
  logic [NK-1:0] done;
  logic [LW:0]   consumed;
  logic          first_done;
  logic [LW-1:0] res_len;

  always_comb begin
    consumed   = {1'b0, pos_i} + (LW+1)'(1);
    first_done = 1'b0;
    res_len    = '0;
    for (int k = 0; k < NK; k++) begin
      base[k] = (k < int'(count_i)) && (len_i[k] != '0);
    end
    alive0 = start_i ? base : alive_i;
    for (int k = 0; k < NK; k++) begin
      alive1[k] = alive0[k] && !((len_i[k] > pos_i) && (kw_byte_i[k] != byte_i));
      done[k]   = alive1[k] && ({1'b0, len_i[k]} <= consumed);
    end
    for (int k = NK - 1; k >= 0; k--) begin
      if (alive1[k]) begin
        first_done = done[k];
      end
      if (done[k]) begin
        res_len = len_i[k];
      end
    end
  end

  // lowest finished keyword is the answer whenever a decision is taken
  always_comb begin
    status_o.act          = start_i || !decided_i;
    status_o.emit         = status_o.act && ((alive1 == '0) || first_done || last_i);
    status_o.match_length = MatchLenW'(res_len);
    alive_o               = alive1;
  end

endmodule

@@ sv/keyword_prefix_matcher.sv @@
// ----------------------------------------------------------------------------
// Keyword prefix matcher
// Finds the lowest-indexed table keyword that is a full prefix of the text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries table writes and text
//   bytes. Keyword bytes and lengths are written at the accepting edge and
//   are seen by every later text byte. A text byte with start_match_i opens
//   a match; one result (match_length_o, 0 when nothing matched) is given on
//   the byte that decides it, later bytes are dropped until the next start.
//   Output channel (out_valid_o / out_stall_i) has a result register.
//   Configuration channel (cfg_valid_i / cfg_ready_o) sets keyword_count,
//   always ready; write it only while the block is idle.
//   A deciding text byte is accepted into the input register, with the
//   keyword bank read beside it, and then goes through evaluation into
//   the result register.
//   Throughput: one item per cycle while in_stall_o is low; the keyword
//   banks are read at one address per cycle, all keywords in parallel.
//   Reset clears lengths, count and match state; keyword bytes are unknown
//   until written. While a result waits under stall and another result is
//   ready behind it, in_stall_o is raised.
// ----------------------------------------------------------------------------
`include "keyword_prefix_matcher_assert.svh"

module keyword_prefix_matcher import kpm_pkg::*; #(
  parameter int unsigned MAX_KEYWORDS    = 16,
  parameter int unsigned MAX_KEYWORD_LEN = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic [KwIdxW-1:0]    keyword_index_i,
  input  logic [CharIdxW-1:0]  char_index_i,
  input  logic [ByteW-1:0]     byte_value_i,
  input  logic [KwLenW-1:0]    keyword_length_i,
  input  logic                 start_match_i,
  input  logic                 end_of_text_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MatchLenW-1:0] match_length_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [KwCountW-1:0]  cfg_data_i
);

  localparam int unsigned NK = MAX_KEYWORDS;
  localparam int unsigned KL = MAX_KEYWORD_LEN;
  localparam int unsigned LW = $clog2(KL + 1);
  localparam int unsigned AW = (KL > 1) ? $clog2(KL) : 1;

  logic                 in_acc;
  logic                 kw_we;
  logic                 len_we;
  logic                 text_acc;
  logic [LW-1:0]        rd_pos;
  logic [LW-1:0]        kw_len_sat;

  logic [LW-1:0]        pos_q, pos_d;
  logic                 s1_valid_q;
  logic                 s1_start_q;
  logic                 s1_last_q;
  logic [LW-1:0]        s1_pos_q;
  logic [ByteW-1:0]     s1_byte_q;
  logic [NK-1:0]        alive_q;
  logic                 decided_q;
  logic [LW-1:0]        lens_q [NK];
  logic [KwCountW-1:0]  count_q;
  logic                 out_valid_q;
  logic [MatchLenW-1:0] match_length_q;

  logic [ByteW-1:0]     kw_rd [NK];
  logic [NK-1:0]        alive_nxt;
  eval_t                st;
  logic                 out_free;
  logic                 s1_move;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && (!st.emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    kw_we    = 1'b0;
    len_we   = 1'b0;
    text_acc = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_KW_BYTE: kw_we    = in_acc && (int'(keyword_index_i) < NK)
                                     && (int'(char_index_i) < KL);
      CMD_KW_LEN:  len_we   = in_acc && (int'(keyword_index_i) < NK);
      CMD_TEXT:    text_acc = in_acc;
      default: ;
    endcase
  end

  assign rd_pos     = start_match_i ? '0 : pos_q;
  assign pos_d      = (rd_pos == LW'(KL)) ? rd_pos : rd_pos + LW'(1);
  assign kw_len_sat = (int'(keyword_length_i) > KL) ? LW'(KL) : LW'(keyword_length_i);

  for (genvar k = 0; k < NK; k++) begin : g_bank
    kpm_kw_bank #(
      .DEPTH(KL)
    ) u_bank (
      .clk_i,
      .we_i (kw_we && (int'(keyword_index_i) == k)),
      .wa_i (AW'(char_index_i)),
      .wd_i (byte_value_i),
      .re_i (text_acc),
      .ra_i (AW'(rd_pos)),
      .rd_o (kw_rd[k])
    );
  end

  kpm_eval #(
    .NK(NK),
    .KL(KL)
  ) u_eval (
    .start_i   (s1_start_q),
    .last_i    (s1_last_q),
    .decided_i (decided_q),
    .alive_i   (alive_q),
    .pos_i     (s1_pos_q),
    .byte_i    (s1_byte_q),
    .kw_byte_i (kw_rd),
    .len_i     (lens_q),
    .count_i   (count_q),
    .alive_o   (alive_nxt),
    .status_o  (st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
      count_q    <= '0;
    end else begin
      if (text_acc) begin
        pos_q <= pos_d;
      end
      s1_valid_q <= text_acc || (s1_valid_q && !s1_move);
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_acc) begin
      s1_start_q <= start_match_i;
      s1_last_q  <= end_of_text_i;
      s1_pos_q   <= rd_pos;
      s1_byte_q  <= byte_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NK; k++) begin
        lens_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NK; k++) begin
        if (len_we && (int'(keyword_index_i) == k)) begin
          lens_q[k] <= kw_len_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q   <= '0;
      decided_q <= 1'b1;
    end else if (s1_move && st.act) begin
      alive_q   <= alive_nxt;
      decided_q <= st.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && st.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && st.emit) begin
      match_length_q <= st.match_length;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_length_o = match_length_q;

  `KPM_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "stall without a blocked result")
  `KPM_ASSERT(a_emit_decides, (s1_move && st.emit) |=> decided_q, "result given but match still open")
  `KPM_ASSERT(a_open_alive, !decided_q |-> (alive_q != '0), "open match with no alive keyword")
  `KPM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

@@ sim/kpm_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword prefix matcher checker
// Mirrors the keyword table, count and match state from accepted items and
// configuration writes, predicts each match length and compares it with the
// results taken from the output channel, oldest first.
// ----------------------------------------------------------------------------
module kpm_match_checker import kpm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic [KwIdxW-1:0]    keyword_index_i,
  input  logic [CharIdxW-1:0]  char_index_i,
  input  logic [ByteW-1:0]     byte_value_i,
  input  logic [KwLenW-1:0]    keyword_length_i,
  input  logic                 start_match_i,
  input  logic                 end_of_text_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [MatchLenW-1:0] match_length_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [KwCountW-1:0]  cfg_data_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o,
  output int unsigned          results_o,
  output int unsigned          hits_o
);

  localparam int NumKw = 16;
  localparam int KwMax = 32;

  logic [ByteW-1:0]     kw_byte [NumKw][KwMax];
  logic [KwLenW-1:0]    kw_len [NumKw];
  logic [NumKw-1:0]     alive;
  logic [KwLenW-1:0]    text_pos;
  logic                 decided;
  logic [KwCountW-1:0]  kw_count;
  logic [MatchLenW-1:0] due_len [$];
  logic [MatchLenW-1:0] want;

  task automatic conclude(input logic [MatchLenW-1:0] len);
    due_len.push_back(len);
    decided = 1'b1;
  endtask

  task automatic step_text(input logic [ByteW-1:0] b, input logic opens, input logic closes);
    int n;
    int used;
    int lead;
    logic [MatchLenW-1:0] alt;
    if (opens) begin
      n = (kw_count > NumKw) ? NumKw : kw_count;
      alive = '0;
      for (int k = 0; k < n; k++)
        if (kw_len[k] != 0) alive[k] = 1'b1;
      text_pos = '0;
      decided = 1'b0;
    end else if (decided) begin
      return;
    end
    for (int k = 0; k < NumKw; k++)
      if (alive[k] && kw_len[k] > text_pos)
        if (text_pos >= KwMax || kw_byte[k][text_pos] != b) alive[k] = 1'b0;
    used = text_pos + 1;
    lead = -1;
    for (int k = NumKw - 1; k >= 0; k--)
      if (alive[k]) lead = k;
    if (lead < 0) begin
      conclude('0);
    end else if (kw_len[lead] <= used) begin
      conclude(kw_len[lead]);
    end else if (closes) begin
      // text exhausted: fall back to the first shorter keyword still alive
      alt = '0;
      for (int k = NumKw - 1; k > lead; k--)
        if (alive[k] && kw_len[k] <= used) alt = kw_len[k];
      conclude(alt);
    end else begin
      text_pos = KwLenW'(used);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKw; k++) kw_len[k] = '0;
      alive = '0;
      text_pos = '0;
      decided = 1'b1;
      kw_count = '0;
      due_len.delete();
      errors_o = 0;
      pending_o = 0;
      results_o = 0;
      hits_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) kw_count = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        case (cmd_i)
          CMD_KW_BYTE: kw_byte[keyword_index_i][char_index_i] = byte_value_i;
          CMD_KW_LEN: begin
            kw_len[keyword_index_i] = (keyword_length_i > KwMax) ? KwLenW'(KwMax)
                                                                 : keyword_length_i;
          end
          CMD_TEXT: step_text(byte_value_i, start_match_i, end_of_text_i);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (match_length_i != 0) hits_o++;
        if (due_len.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected result, match_length %0d", $time, match_length_i);
        end else begin
          want = due_len.pop_front();
          if (match_length_i !== want) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: match_length expected %0d, got %0d", $time, want,
                       match_length_i);
          end
        end
      end
      pending_o = due_len.size();
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword prefix matcher testbench
// Loads keyword tables built on shared prefixes, then streams full, truncated,
// corrupted and random text against them under several keyword counts, with
// table writes mixed into matches and random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import kpm_pkg::*;

  localparam int NumKw      = 16;
  localparam int KwMax      = 32;
  localparam int ItemTarget = 420;
  localparam int CycleLimit = 400000;
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CmdW-1:0]      cmd_i = CMD_TEXT;
  logic [KwIdxW-1:0]    keyword_index_i = '0;
  logic [CharIdxW-1:0]  char_index_i = '0;
  logic [ByteW-1:0]     byte_value_i = '0;
  logic [KwLenW-1:0]    keyword_length_i = '0;
  logic                 start_match_i = 1'b0;
  logic                 end_of_text_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [MatchLenW-1:0] match_length_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [KwCountW-1:0]  cfg_data_i = '0;

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned hits;
  bit          idling = 1'b0;
  int          stall_left = 0;
  int unsigned cycles = 0;
  int          items = 0;
  int          count_writes = 0;
  int          active = 0;

  // table as loaded, used to shape the text
  logic [ByteW-1:0] words [NumKw][KwMax];
  logic [KwMax-1:0] filled [NumKw];
  int               word_len [NumKw];
  logic [ByteW-1:0] alphabet [4];

  keyword_prefix_matcher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .keyword_index_i  (keyword_index_i),
    .char_index_i     (char_index_i),
    .byte_value_i     (byte_value_i),
    .keyword_length_i (keyword_length_i),
    .start_match_i    (start_match_i),
    .end_of_text_i    (end_of_text_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .match_length_o   (match_length_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  kpm_match_checker match_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .cmd_i            (cmd_i),
    .keyword_index_i  (keyword_index_i),
    .char_index_i     (char_index_i),
    .byte_value_i     (byte_value_i),
    .keyword_length_i (keyword_length_i),
    .start_match_i    (start_match_i),
    .end_of_text_i    (end_of_text_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .match_length_i   (match_length_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .errors_o         (errors),
    .pending_o        (pending),
    .results_o        (results),
    .hits_o           (hits)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb failed");
      $finish;
    end
  end

  // result side back-pressure in random bursts while idling is set
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [KwIdxW-1:0] kidx,
                           input logic [CharIdxW-1:0] cidx, input logic [ByteW-1:0] b,
                           input logic [KwLenW-1:0] klen, input logic opens,
                           input logic closes);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    cmd_i = cmd;
    keyword_index_i = kidx;
    char_index_i = cidx;
    byte_value_i = b;
    keyword_length_i = klen;
    start_match_i = opens;
    end_of_text_i = closes;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items++;
  endtask

  task automatic put_byte(input int k, input int c, input logic [ByteW-1:0] b);
    send_item(CMD_KW_BYTE, KwIdxW'(k), CharIdxW'(c), b, KwLenW'($urandom),
              1'($urandom), 1'($urandom));
    words[k][c] = b;
    filled[k][c] = 1'b1;
  endtask

  // bytes below the new length are written first, so no unwritten byte is ever compared
  task automatic put_length(input int k, input logic [KwLenW-1:0] n);
    int eff;
    eff = (n > KwMax) ? KwMax : n;
    for (int c = 0; c < eff; c++)
      if (!filled[k][c]) put_byte(k, c, alphabet[$urandom_range(0, 3)]);
    send_item(CMD_KW_LEN, KwIdxW'(k), CharIdxW'($urandom), ByteW'($urandom), n,
              1'($urandom), 1'($urandom));
    word_len[k] = eff;
  endtask

  task automatic put_text(input logic [ByteW-1:0] b, input logic opens, input logic closes);
    send_item(CMD_TEXT, KwIdxW'($urandom), CharIdxW'($urandom), b, KwLenW'($urandom),
              opens, closes);
  endtask

  task automatic set_count(input logic [KwCountW-1:0] n);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_data_i = n;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    active = (n > NumKw) ? NumKw : n;
    count_writes++;
  endtask

  task automatic load_table(input int span);
    int n;
    int eff;
    logic [ByteW-1:0] root [KwMax];
    for (int i = 0; i < 4; i++) alphabet[i] = ByteW'($urandom);
    for (int c = 0; c < KwMax; c++) root[c] = alphabet[$urandom_range(0, 3)];
    for (int k = 0; k < span; k++) begin
      case ($urandom_range(0, 15))
        0: n = 0;
        1: n = $urandom_range(33, 63);
        2: n = KwMax;
        default: n = $urandom_range(1, 6);
      endcase
      eff = (n > KwMax) ? KwMax : n;
      for (int c = 0; c < eff; c++)
        put_byte(k, c, ($urandom_range(0, 3) == 0) ? alphabet[$urandom_range(0, 3)] : root[c]);
      put_length(k, KwLenW'(n));
    end
  endtask

  task automatic text_run();
    int k;
    int n;
    int mode;
    int p;
    logic closes;
    logic [ByteW-1:0] flip;
    logic [ByteW-1:0] seq [$];
    k = (active > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, active - 1)
                                                   : $urandom_range(0, NumKw - 1);
    n = word_len[k];
    mode = (n == 0) ? 5 : $urandom_range(0, 5);
    for (int c = 0; c < n; c++) seq.push_back(words[k][c]);
    closes = 1'b0;
    case (mode)
      0, 1: begin
        repeat ($urandom_range(0, 3)) seq.push_back(alphabet[$urandom_range(0, 3)]);
        closes = 1'($urandom_range(0, 1));
      end
      2: begin
        p = $urandom_range(1, n);
        while (seq.size() > p) void'(seq.pop_back());
        closes = 1'b1;
      end
      3: begin
        p = $urandom_range(0, n - 1);
        flip = ByteW'($urandom_range(1, 255));
        seq[p] = seq[p] ^ flip;
        repeat (2) seq.push_back(alphabet[$urandom_range(0, 3)]);
      end
      4: closes = 1'b1;
      default: begin
        seq.delete();
        repeat ($urandom_range(1, 6)) seq.push_back(alphabet[$urandom_range(0, 3)]);
        closes = 1'($urandom_range(0, 1));
      end
    endcase
    for (int i = 0; i < seq.size(); i++)
      put_text(seq[i], i == 0, closes && i == seq.size() - 1);
    // trailing bytes without a start: dropped once the match is decided
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2))
        put_text(alphabet[$urandom_range(0, 3)], 1'b0, 1'($urandom));
  endtask

  task automatic noise();
    case ($urandom_range(0, 4))
      0: put_byte($urandom_range(0, NumKw - 1), $urandom_range(0, KwMax - 1),
                  ByteW'($urandom));
      1: put_length($urandom_range(0, NumKw - 1),
                    KwLenW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                        : $urandom_range(0, 6)));
      2: send_item(CMD_SPARE, KwIdxW'($urandom), CharIdxW'($urandom), ByteW'($urandom),
                   KwLenW'($urandom), 1'($urandom), 1'($urandom));
      3: put_text(ByteW'($urandom), 1'b0, 1'($urandom));
      default: begin
        // table write in the middle of a match
        put_text(alphabet[$urandom_range(0, 3)], 1'b1, 1'b0);
        if ($urandom_range(0, 1) == 0)
          put_length($urandom_range(0, NumKw - 1), KwLenW'($urandom_range(0, 4)));
        else
          put_byte($urandom_range(0, NumKw - 1), $urandom_range(0, 3),
                   alphabet[$urandom_range(0, 3)]);
        put_text(alphabet[$urandom_range(0, 3)], 1'b0, 1'($urandom));
      end
    endcase
  endtask

  initial begin
    int phase;
    for (int k = 0; k < NumKw; k++) begin
      filled[k] = '0;
      word_len[k] = 0;
    end
    for (int i = 0; i < 4; i++) alphabet[i] = ByteW'($urandom);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    put_text(8'h00, 1'b0, 1'b0);
    put_text(8'hFF, 1'b1, 1'b1);
    send_item(CMD_SPARE, '1, '1, '1, '1, 1'b1, 1'b1);
    put_byte(0, 0, 8'h00);
    put_byte(0, 1, 8'hFF);
    put_length(0, 6'd2);
    put_byte(1, 0, 8'h00);
    put_length(1, 6'd1);
    put_byte(NumKw - 1, KwMax - 1, 8'hA5);
    set_count('1);
    put_text(8'h00, 1'b1, 1'b0);
    put_text(8'hFF, 1'b0, 1'b0);
    put_text(8'h00, 1'b1, 1'b1);
    put_text(8'h00, 1'b1, 1'b0);
    put_text(8'h11, 1'b0, 1'b0);
    put_text(8'hFF, 1'b0, 1'b1);
    put_text(8'h55, 1'b1, 1'b0);
    put_text(8'h00, 1'b1, 1'b0);
    put_length(0, 6'd1);
    put_text(8'h77, 1'b0, 1'b0);
    put_text(8'h00, 1'b1, 1'b1);

    idling = 1'b1;
    load_table(NumKw);
    phase = 0;
    while (items < ItemTarget) begin
      idling = (items < ItemTarget - 80) && (phase % 3 != 2);
      case (phase % 5)
        0: set_count(5'd16);
        1: set_count(KwCountW'($urandom_range(1, 15)));
        2: set_count('1);
        3: begin
          if (phase == 3) set_count('0);
          else set_count(KwCountW'($urandom_range(17, 31)));
        end
        default: begin
          load_table($urandom_range(2, 8));
          set_count(KwCountW'($urandom_range(0, 31)));
        end
      endcase
      repeat (12) begin
        if ($urandom_range(0, 5) == 0) noise();
        else text_run();
      end
      phase++;
    end

    in_valid_i = 1'b0;
    idling = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("%0d items sent over %0d keyword count settings, table loads included",
             items, count_writes);
    $display("%0d match results checked, %0d of them nonzero, %0d mismatches",
             results, hits, errors);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/kpm_pkg.sv
sv/kpm_kw_bank.sv
sv/kpm_eval.sv
sv/keyword_prefix_matcher.sv
sim/kpm_match_checker.sv
sim/tb.sv
